[src/ddo_pkg.sv]
// Shared types, constants and CORDIC angle table for the odometry core.
`default_nettype none
package ddo_pkg;
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_BITS = 5;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_CLEAR_POS = 2'd1,
		OP_CLEAR_DIST = 2'd2,
		OP_NOP = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_FORWARD = 2'd1,
		MODE_ROTATE = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0,
		REG_CW = 3'd1,
		REG_LIMIT = 3'd2,
		REG_TRAVEL = 3'd3,
		REG_FTURN = 3'd4,
		REG_RTURN = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LAUNCH,
		ST_CORDIC,
		ST_MULX,
		ST_MULY,
		ST_UPDATE,
		ST_OUT
	} state_t;

	function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933405;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335086;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41721;
			5'd15: v = 32'd20860;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2607;
			5'd19: v = 32'd1303;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

[src/ddo_cordic.sv]
// Iterative CORDIC that yields sine and cosine in Q.30, one rotation per cycle.
`default_nettype none
module ddo_cordic import ddo_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [31:0] angle,
	output logic done,
	output logic signed [33:0] sin_val,
	output logic signed [33:0] cos_val
);
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [STEP_BITS-1:0] step_q;
	logic busy_q, flip_q;
	logic [31:0] a_rot;
	logic signed [33:0] dx, dy;

	assign a_rot = (angle[31] ^ angle[30]) ? angle + 32'h8000_0000 : angle;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= {a_rot[31], a_rot};
			flip_q <= angle[31] ^ angle[30];
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed({1'b0, atan_turn(step_q)});
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed({1'b0, atan_turn(step_q)});
			end
		end
	end

	assign sin_val = flip_q ? -y_q : y_q;
	assign cos_val = flip_q ? -x_q : x_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("cordic done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("cordic did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("cordic done twice");
endmodule
`default_nettype wire

[src/differential_drive_odometry_core.sv]
// Top level of the differential-drive odometry core.
//
// Channel   Direction  Contents
// s_axis    in         tuser: opcode[1:0]; tdata: left_delta[7:0], right_delta[15:8]
// m_axis    out        tdata: pos_x, pos_y, heading, distance_travelled, total_turn; tuser: rejected
// cfg       in         cfg_index selects a register, cfg_data carries its value
//
// A forward update passes from acceptance to result through a prepare state, a launch
// state, the CORDIC rotations and done, two multiply states sharing one multiplier,
// an update state and the hand-off into the output register. Other requests go from
// the prepare state straight to the update state. The core takes one request at a time.
// Reset clears all pose and accumulator state and loads the register defaults.
// A result waits in its own output register until taken, so the core goes back to idle
// at once; it stalls in the hand-off only while an older result has not been taken.
`default_nettype none
module differential_drive_odometry_core import ddo_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [15:0] s_axis_tdata, // left_delta, right_delta
	input  wire logic [1:0] s_axis_tuser, // opcode
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [151:0] m_axis_tdata, // pos_x, pos_y, heading, distance, total_turn
	output logic m_axis_tuser, // rejected
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [19:0] cfg_data
);
	state_t state_q, state_d;
	mode_t mode_q;
	logic cw_q;
	logic [6:0] limit_q;
	logic [15:0] travel_q;
	logic [19:0] fturn_q, rturn_q;

	logic signed [31:0] x_q, y_q, dist_q;
	logic [23:0] head_q;
	logic [31:0] turn_q;
	logic rej_q, out_valid_q;
	logic [151:0] out_data_q;
	logic out_rej_q;
	logic out_load;

	opcode_t op_q;
	logic signed [7:0] l_q, r_q;
	logic signed [25:0] d2_q;     // travel * (l + r)
	logic signed [29:0] dturn_q;  // fturn * (r - l), or +/- rturn * l in other modes
	logic signed [33:0] sin_c, cos_c;
	logic signed [61:0] prod;
	logic signed [61:0] px_q, py_q;
	logic signed [33:0] mul_b;
	logic cordic_start, cordic_done;
	logic signed [29:0] dturn_mag, half_turn;
	logic [23:0] mid;
	logic [32:0] turn_next;
	logic go_forward;

	logic signed [8:0] sum_lr, dif_lr;
	logic signed [7:0] lim_s;
	logic bad;

	// One shared multiplier serves both projections.
	assign mul_b = (state_q == ST_MULX) ? sin_c : cos_c;
	assign prod = 62'(d2_q) * 62'(mul_b);

	// The mid-turn angle uses half the turn, rounded to nearest with ties away from zero.
	assign dturn_mag = (dturn_q < 0) ? -dturn_q : dturn_q;
	assign half_turn = (dturn_mag + 30'sd1) >>> 1;
	assign mid = (dturn_q < 0) ? head_q - half_turn[23:0] : head_q + half_turn[23:0];
	assign turn_next = {1'b0, turn_q} + {3'd0, dturn_mag};

	ddo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start),
		.angle({mid, 8'd0}), .done(cordic_done),
		.sin_val(sin_c), .cos_val(cos_c)
	);

	function automatic logic signed [31:0] round31_add(input logic signed [31:0] acc,
		input logic signed [61:0] p);
		logic [61:0] mag;
		logic signed [33:0] inc, sum;
		mag = p[61] ? 62'(-p) : 62'(p);
		inc = 34'(($unsigned(mag) + 62'h4000_0000) >> 31);
		if (p[61]) inc = -inc;
		sum = 34'(acc) + inc;
		if (sum > 34'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (sum < -34'sh8000_0000) return -32'sh8000_0000;
		return sum[31:0];
	endfunction

	// Registers change only between requests, so a write never lands mid-computation.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_rej_q;
	assign go_forward = (op_q == OP_UPDATE) && !bad && (mode_q == MODE_FORWARD);
	assign cordic_start = (state_q == ST_LAUNCH);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_PREP;
			ST_PREP: state_d = go_forward ? ST_LAUNCH : ST_UPDATE;
			ST_LAUNCH: state_d = ST_CORDIC;
			ST_CORDIC: if (cordic_done) state_d = ST_MULX;
			ST_MULX: state_d = ST_MULY;
			ST_MULY: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF; cw_q <= 1'b1; limit_q <= 7'd5;
			travel_q <= 16'd1979; fturn_q <= 20'd60176; rturn_q <= 20'd120347;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				REG_CW: cw_q <= cfg_data[0];
				REG_LIMIT: limit_q <= cfg_data[6:0];
				REG_TRAVEL: travel_q <= cfg_data[15:0];
				REG_FTURN: fturn_q <= cfg_data;
				REG_RTURN: rturn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Prepare cycle computes the rejection flag and the two products.
	assign lim_s = $signed({1'b0, limit_q});
	assign bad = (l_q > lim_s) || (l_q < -lim_s) || (r_q > lim_s) || (r_q < -lim_s);
	assign sum_lr = 9'(l_q) + 9'(r_q);
	assign dif_lr = 9'(r_q) - 9'(l_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			op_q <= opcode_t'(s_axis_tuser);
			l_q <= s_axis_tdata[7:0];
			r_q <= s_axis_tdata[15:8];
		end
		if (state_q == ST_IDLE && s_axis_tvalid) rej_q <= 1'b0;
		if (state_q == ST_PREP) begin
			rej_q <= (op_q == OP_UPDATE) && bad;
			d2_q <= 26'($signed({1'b0, travel_q}) * sum_lr);
			if (mode_q == MODE_FORWARD)
				dturn_q <= 30'($signed({1'b0, fturn_q}) * dif_lr);
			else
				dturn_q <= cw_q ? 30'($signed({1'b0, rturn_q}) * l_q)
					: 30'(-($signed({1'b0, rturn_q}) * l_q));
		end
		if (state_q == ST_MULX) px_q <= prod;
		if (state_q == ST_MULY) py_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; dist_q <= '0; head_q <= '0; turn_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (op_q == OP_CLEAR_POS) begin
				x_q <= '0; y_q <= '0;
			end else if (op_q == OP_CLEAR_DIST) begin
				dist_q <= '0;
			end else if (op_q == OP_UPDATE && !rej_q) begin
				if (mode_q == MODE_FORWARD) begin
					x_q <= round31_add(x_q, px_q);
					y_q <= round31_add(y_q, py_q);
					head_q <= head_q + dturn_q[23:0];
					dist_q <= round31_add(dist_q, 62'(d2_q) <<< 30);
				end else if (mode_q == MODE_ROTATE) begin
					head_q <= head_q + dturn_q[23:0];
					turn_q <= turn_next[32] ? 32'hFFFF_FFFF : turn_next[31:0];
				end
			end
		end
	end

	// Output register: holds a result until taken, loaded only when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {turn_q, dist_q, head_q, y_q, x_q};
			out_rej_q <= rej_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("accepted two requests at once");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("waiting result changed or dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == ST_CORDIC))
		else $error("cordic finished unexpectedly");
endmodule
`default_nettype wire
